### rtl/core/exp_adsr_envelope_bank_unit_macros.svh
// ----------------------------------------------------------------------------
// exp_adsr_envelope_bank_unit macros
// assertion shorthands for the envelope bank, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef EXP_ADSR_ENVELOPE_BANK_UNIT_MACROS_SVH
`define EXP_ADSR_ENVELOPE_BANK_UNIT_MACROS_SVH

// same-cycle implication
`define EAEB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EAEB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/eaeb_pkg.sv
// ----------------------------------------------------------------------------
// eaeb_pkg
// widths, stage codes, register indexes and voice state type of the bank
// ----------------------------------------------------------------------------
package eaeb_pkg;

  localparam int VOICES     = 64;
  localparam int VOICE_W    = $clog2(VOICES);
  localparam int FRAC_BITS  = 24;
  localparam int DELAY_BITS = 24;
  localparam int COEF_W     = 24;
  localparam int ENV_W      = FRAC_BITS + 1;
  localparam int SHAPE_W    = 32;
  localparam int SAMPLE_W   = 32;
  localparam int STAGE_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // shared multiplier: a is shape+one, a shape, an envelope, sustain or |gain|, b is an envelope or pole term
  localparam int MUL_A_W = SHAPE_W + 1;
  localparam int MUL_B_W = ENV_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int XW_W    = ACC_W - FRAC_BITS;
  localparam int MAG_W   = PROD_W - FRAC_BITS;

  localparam logic [ENV_W-1:0]      ONE_Q       = ENV_W'(1) << FRAC_BITS;
  localparam logic [ENV_W-1:0]      QUIET_LEVEL = ENV_W'((64'd1 << FRAC_BITS) / 1000000);
  localparam logic [DELAY_BITS-1:0] DELAY_MAX   = '1;

  localparam logic [SHAPE_W-1:0]  SHAPE_RESET = 32'd16777;
  localparam logic [SAMPLE_W-1:0] GAIN_RESET  = 32'd16777216;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = 32'h7fff_ffff;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN  = 32'h8000_0000;

  localparam logic [STAGE_W-1:0] ST_OFF     = 3'd0;
  localparam logic [STAGE_W-1:0] ST_DELAY   = 3'd1;
  localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd2;
  localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd3;
  localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd4;
  localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_COEF    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_SHAPE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_SHAPE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN   = 3'd7;

  typedef struct packed {
    logic [ENV_W-1:0]      env;
    logic [STAGE_W-1:0]    stage;
    logic                  pg;
    logic [DELAY_BITS-1:0] dcnt;
  } vstate_t;

endpackage

### rtl/core/eaeb_in_if.sv
// ----------------------------------------------------------------------------
// eaeb_in_if
// sample tick request channel: voice, gate and loop flag
// ----------------------------------------------------------------------------
interface eaeb_in_if;
  import eaeb_pkg::*;

  logic               valid;
  logic               ready;
  logic [VOICE_W-1:0] voice;
  logic               gate;
  logic               loop_mode;

  modport source (output valid, voice, gate, loop_mode, input ready);
  modport sink   (input valid, voice, gate, loop_mode, output ready);
endinterface

### rtl/core/eaeb_out_if.sv
// ----------------------------------------------------------------------------
// eaeb_out_if
// result channel: scaled envelope sample and current stage
// ----------------------------------------------------------------------------
interface eaeb_out_if;
  import eaeb_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic [STAGE_W-1:0]         stage_now;

  modport source (output valid, sample_out, stage_now, input ready);
  modport sink   (input valid, sample_out, stage_now, output ready);
endinterface

### rtl/core/eaeb_cfg_if.sv
// ----------------------------------------------------------------------------
// eaeb_cfg_if
// register write channel: register index and write data
// ----------------------------------------------------------------------------
interface eaeb_cfg_if;
  import eaeb_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/exp_adsr_envelope_bank_unit.sv
// ----------------------------------------------------------------------------
// exp_adsr_envelope_bank_unit: 64-voice exponential envelope, one request a tick
// requests taken only when idle; off/delay/sustain need no product term, attack
// and release two, decay three; shared 33x25 multiplier, products accumulated;
// result valid in the same cycle the next request can be taken; sync reset clears
// control, loads config defaults; voice state reads as zero until first written
// ----------------------------------------------------------------------------
`include "exp_adsr_envelope_bank_unit_macros.svh"

module exp_adsr_envelope_bank_unit (
  input logic        clk,
  input logic        rst_n,
  eaeb_in_if.sink    in_if,
  eaeb_out_if.source out_if,
  eaeb_cfg_if.sink   cfg_if
);
  import eaeb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EDGE = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_GAIN = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // configuration
  logic [COEF_W-1:0]         delay_samples_r;
  logic [COEF_W-1:0]         attack_coef_r;
  logic [COEF_W-1:0]         decay_coef_r;
  logic [COEF_W-1:0]         release_coef_r;
  logic [ENV_W-1:0]          sustain_level_r;
  logic [SHAPE_W-1:0]        attack_shape_r;
  logic [SHAPE_W-1:0]        release_shape_r;
  logic [SAMPLE_W-1:0]       output_gain_r;

  // control
  logic [2:0]                state_r, state_nxt;
  logic [1:0]                step_r;
  logic [VOICES-1:0]         vld_r;
  logic                      out_valid_r;

  // payload
  logic [VOICE_W-1:0]        voice_r;
  logic                      gate_r;
  logic                      loop_r;
  vstate_t                   rd_data_r;
  logic                      rd_vld_r;
  vstate_t                   cur_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      sub_r;
  logic                      neg_r;
  logic [ACC_W-1:0]          acc_r;
  logic [SAMPLE_W-1:0]       out_sample_r;
  logic [STAGE_W-1:0]        out_stage_r;

  vstate_t                   state_mem [VOICES];

  logic                      in_acc;
  logic                      out_free;
  logic [ENV_W-1:0]          sus;
  logic [SHAPE_W-1:0]        ashape;
  logic [SHAPE_W-1:0]        rshape;
  logic [DELAY_BITS-1:0]     delay_lim;
  vstate_t                   s0, s1, s2;
  logic [DELAY_BITS-1:0]     dc_inc;
  logic                      needs_mul;
  logic [COEF_W-1:0]         coef_sel;
  logic [ENV_W-1:0]          cc;
  logic [ENV_W-1:0]          omc;
  logic [MUL_A_W-1:0]        gain_ext;
  logic [MUL_A_W-1:0]        gain_abs;
  logic [MUL_A_W-1:0]        mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      mul_sub;
  logic [1:0]                last_step;
  logic [XW_W-1:0]           xw;
  vstate_t                   upd;
  logic [PROD_W-1:0]         rnd;
  logic [MAG_W-1:0]          mag;
  logic [SAMPLE_W-1:0]       sample_nxt;

  function automatic vstate_t start_attack(input vstate_t s);
    vstate_t t;
    t = s;
    if (attack_coef_r == '0) begin
      t.stage = ST_DECAY;
      t.env   = ONE_Q;
    end else begin
      t.stage = ST_ATTACK;
    end
    return t;
  endfunction

  function automatic vstate_t trigger_voice(input vstate_t s);
    vstate_t t;
    t = s;
    if (delay_samples_r == '0) begin
      t = start_attack(s);
    end else begin
      if (s.env <= QUIET_LEVEL) begin
        t.env  = '0;
        t.dcnt = '0;
      end
      t.stage = ST_DELAY;
    end
    return t;
  endfunction

  assign in_acc       = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_free     = !out_valid_r || out_if.ready;

  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_sample_r;
  assign out_if.stage_now  = out_stage_r;

  // saturated shared parameters
  assign sus       = (sustain_level_r > ONE_Q) ? ONE_Q : sustain_level_r;
  assign ashape    = (attack_shape_r == '0) ? SHAPE_W'(1) : attack_shape_r;
  assign rshape    = (release_shape_r == '0) ? SHAPE_W'(1) : release_shape_r;
  assign delay_lim = (32'(delay_samples_r) > 32'(DELAY_MAX)) ? DELAY_MAX
                                                            : DELAY_BITS'(delay_samples_r);
  assign gain_ext  = {output_gain_r[SAMPLE_W-1], output_gain_r};
  assign gain_abs  = gain_ext[MUL_A_W-1] ? (~gain_ext + MUL_A_W'(1)) : gain_ext;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_samples_r <= '0;
      attack_coef_r   <= '0;
      decay_coef_r    <= '0;
      release_coef_r  <= '0;
      sustain_level_r <= ONE_Q;
      attack_shape_r  <= SHAPE_RESET;
      release_shape_r <= SHAPE_RESET;
      output_gain_r   <= GAIN_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_DELAY_SAMPLES: delay_samples_r <= cfg_if.data[COEF_W-1:0];
        REG_ATTACK_COEF:   attack_coef_r   <= cfg_if.data[COEF_W-1:0];
        REG_DECAY_COEF:    decay_coef_r    <= cfg_if.data[COEF_W-1:0];
        REG_RELEASE_COEF:  release_coef_r  <= cfg_if.data[COEF_W-1:0];
        REG_SUSTAIN_LEVEL: sustain_level_r <= cfg_if.data[ENV_W-1:0];
        REG_ATTACK_SHAPE:  attack_shape_r  <= cfg_if.data[SHAPE_W-1:0];
        REG_RELEASE_SHAPE: release_shape_r <= cfg_if.data[SHAPE_W-1:0];
        REG_OUTPUT_GAIN:   output_gain_r   <= cfg_if.data[SAMPLE_W-1:0];
      endcase
    end
  end

  // voice state memory, read on request, written back before the result
  always_ff @(posedge clk) begin
    if (state_r == S_GAIN) begin
      state_mem[voice_r] <= cur_r;
    end
    if (in_acc) begin
      rd_data_r <= state_mem[in_if.voice];
      rd_vld_r  <= vld_r[in_if.voice];
      voice_r   <= in_if.voice;
      gate_r    <= in_if.gate;
      loop_r    <= in_if.loop_mode;
    end
  end

  // gate edge, then the stages that need no product
  always_comb begin
    s0        = rd_vld_r ? rd_data_r : '0;
    s1        = s0;
    needs_mul = 1'b0;
    dc_inc    = '0;
    if (!s0.pg && gate_r) begin
      s1 = trigger_voice(s0);
    end else if (s0.pg && !gate_r) begin
      s1.stage = ST_RELEASE;
    end
    s1.pg = gate_r;
    s2    = s1;
    unique case (s1.stage)
      ST_DELAY: begin
        dc_inc  = (s1.dcnt < DELAY_MAX) ? s1.dcnt + DELAY_BITS'(1) : s1.dcnt;
        s2.dcnt = dc_inc;
        if (dc_inc >= delay_lim) begin
          s2.dcnt = '0;
          s2      = start_attack(s2);
        end
      end
      ST_ATTACK, ST_DECAY, ST_RELEASE: begin
        needs_mul = 1'b1;
      end
      ST_SUSTAIN: begin
        s2.env = sus;
        if (loop_r) begin
          s2 = trigger_voice(s2);
        end
      end
      default: begin
        s2.stage = ST_OFF;
        s2.env   = '0;
      end
    endcase
  end

  // multiplier operand selection per stage and term
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    mul_sub   = 1'b0;
    last_step = 2'd1;
    unique case (cur_r.stage)
      ST_ATTACK:  coef_sel = attack_coef_r;
      ST_DECAY:   coef_sel = decay_coef_r;
      ST_RELEASE: coef_sel = release_coef_r;
      default:    coef_sel = '0;
    endcase
    // a 24-bit pole is always below one, so it needs no clamp
    cc  = ENV_W'(coef_sel);
    omc = ONE_Q - cc;
    if (state_r == S_GAIN) begin
      mul_a = gain_abs;
      mul_b = cur_r.env;
    end else begin
      unique case (cur_r.stage)
        ST_ATTACK: begin
          if (step_r == 2'd0) begin
            mul_a = MUL_A_W'(ONE_Q) + MUL_A_W'(ashape);
            mul_b = omc;
          end else begin
            mul_a = MUL_A_W'(cur_r.env);
            mul_b = cc;
          end
        end
        ST_DECAY: begin
          last_step = 2'd2;
          unique case (step_r)
            2'd0: begin
              mul_a = MUL_A_W'(cur_r.env);
              mul_b = cc;
            end
            2'd1: begin
              mul_a = MUL_A_W'(sus);
              mul_b = omc;
            end
            default: begin
              mul_a   = MUL_A_W'(rshape);
              mul_b   = omc;
              mul_sub = 1'b1;
            end
          endcase
        end
        ST_RELEASE: begin
          if (step_r == 2'd0) begin
            mul_a = MUL_A_W'(cur_r.env);
            mul_b = cc;
          end else begin
            mul_a   = MUL_A_W'(rshape);
            mul_b   = omc;
            mul_sub = 1'b1;
          end
        end
        default: begin
          mul_a = '0;
        end
      endcase
    end
  end

  // floor of the accumulated sum, zero when not positive, then clamps
  always_comb begin
    xw  = (acc_r[ACC_W-1] || acc_r == '0) ? '0 : acc_r[ACC_W-1:FRAC_BITS];
    upd = cur_r;
    unique case (cur_r.stage)
      ST_ATTACK: begin
        if (xw >= XW_W'(ONE_Q)) begin
          upd.env   = ONE_Q;
          upd.stage = ST_DECAY;
        end else begin
          upd.env = xw[ENV_W-1:0];
        end
      end
      ST_DECAY: begin
        if (xw <= XW_W'(sus)) begin
          upd.env   = sus;
          upd.stage = ST_SUSTAIN;
        end else begin
          upd.env = xw[ENV_W-1:0];
        end
      end
      ST_RELEASE: begin
        upd.env = xw[ENV_W-1:0];
        if (xw == '0) begin
          upd.stage = ST_OFF;
        end
      end
      default: begin
        upd = cur_r;
      end
    endcase
  end

  // negative products round toward minus infinity, then saturate
  always_comb begin
    rnd = neg_r ? (prod_r + PROD_W'(ONE_Q - ENV_W'(1))) : prod_r;
    mag = rnd[PROD_W-1:FRAC_BITS];
    if (neg_r) begin
      sample_nxt = (mag > MAG_W'(SAMPLE_MIN)) ? SAMPLE_MIN : (~mag[SAMPLE_W-1:0] + 32'd1);
    end else begin
      sample_nxt = (mag > MAG_W'(SAMPLE_MAX)) ? SAMPLE_MAX : mag[SAMPLE_W-1:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_EDGE: begin
        cur_r <= s2;
        acc_r <= '0;
      end
      S_MUL: begin
        prod_r <= mul_a * mul_b;
        sub_r  <= mul_sub;
      end
      S_ACC: begin
        acc_r <= sub_r ? acc_r - ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
      end
      S_UPD: begin
        cur_r <= upd;
      end
      S_GAIN: begin
        prod_r <= mul_a * mul_b;
        neg_r  <= output_gain_r[SAMPLE_W-1];
      end
      S_OUT: begin
        if (out_free) begin
          out_sample_r <= sample_nxt;
          out_stage_r  <= cur_r.stage;
        end
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_EDGE;
      S_EDGE:  state_nxt = needs_mul ? S_MUL : S_GAIN;
      S_MUL:   state_nxt = S_ACC;
      S_ACC:   state_nxt = (step_r == last_step) ? S_UPD : S_MUL;
      S_UPD:   state_nxt = S_GAIN;
      S_GAIN:  state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_EDGE) begin
        step_r <= '0;
      end else if (state_r == S_ACC) begin
        step_r <= step_r + 2'd1;
      end
      if (state_r == S_GAIN) begin
        vld_r[voice_r] <= 1'b1;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `EAEB_ASSERT_IMPL(a_env_full_scale, state_r == S_GAIN, cur_r.env <= ONE_Q, "envelope above full scale")
  `EAEB_ASSERT_IMPL(a_off_silent, (state_r == S_GAIN) && (cur_r.stage == ST_OFF), cur_r.env == '0, "off voice not silent")
  `EAEB_ASSERT_NEXT(a_result_loaded, (state_r == S_OUT) && !out_valid_r, out_valid_r && (state_r == S_IDLE), "result not loaded")

endmodule
